>>> sv/table_driven_event_state_machine_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the table-driven event state machine
// Implication and next-cycle implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef TABLE_DRIVEN_EVENT_STATE_MACHINE_UNIT_ASSERT_SVH
`define TABLE_DRIVEN_EVENT_STATE_MACHINE_UNIT_ASSERT_SVH

// same-cycle implication
`define TDESM_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion violated");

// next-cycle implication
`define TDESM_ASSERT_NXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion violated");

`endif

>>> sv/tdesm_pkg.sv
// ----------------------------------------------------------------------------
// tdesm_pkg
// Shared types and codes of the table-driven event state machine.
// ----------------------------------------------------------------------------
`default_nettype none

package tdesm_pkg;

    localparam int DEF_MAX_STATES      = 16;
    localparam int DEF_MAX_TRANSITIONS = 64;

    localparam logic REG_DEFAULT_STATE = 1'b0;
    localparam logic REG_DEFAULT_EVENT = 1'b1;

    typedef enum logic [1:0] {
        OP_ADD_STATE = 2'd0,
        OP_ADD_TRANS = 2'd1,
        OP_FORCE     = 2'd2,
        OP_EVENT     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CHANGED        = 3'd0,
        ST_SAME           = 3'd1,
        ST_TARGET_MISSING = 3'd2,
        ST_NO_MATCH       = 3'd3,
        ST_NO_STATE       = 3'd4,
        ST_ACCEPTED       = 3'd5,
        ST_FULL           = 3'd6,
        ST_FORCE_MISSING  = 3'd7
    } status_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] state_id;
        logic [7:0] event_id;
        logic [7:0] action_id;
        logic [7:0] next_state_id;
    } item_t;

    typedef struct packed {
        logic [7:0] transition_action;
        logic [7:0] entry_action;
        logic [7:0] current_state;
        logic       current_valid;
        status_t    status;
    } result_t;

    typedef struct packed {
        logic [7:0] default_state_id;
        logic [7:0] default_event_id;
    } cfg_t;

endpackage

`default_nettype wire

>>> sv/tdesm_ram.sv
// ----------------------------------------------------------------------------
// tdesm_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tdesm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/tdesm_seq.sv
// ----------------------------------------------------------------------------
// tdesm_seq
// Item sequencer: owns the state and transition memories, executes adds and
// forces, and scans the memories for event lookups.
// ----------------------------------------------------------------------------
`default_nettype none

module tdesm_seq #(
    parameter int MAX_STATES      = tdesm_pkg::DEF_MAX_STATES,
    parameter int MAX_TRANSITIONS = tdesm_pkg::DEF_MAX_TRANSITIONS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tdesm_pkg::cfg_t   cfg,
    input  wire logic              start,
    input  wire tdesm_pkg::item_t  item,
    output logic                   idle,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output tdesm_pkg::result_t     res
);

    import tdesm_pkg::*;

    localparam int SW  = $clog2(MAX_STATES);
    localparam int TW  = $clog2(MAX_TRANSITIONS);
    localparam int SCW = $clog2(MAX_STATES + 1);
    localparam int TCW = $clog2(MAX_TRANSITIONS + 1);
    localparam int SDW = 16;
    localparam int TDW = 24 + SW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TSCAN,
        S_RESOLVE,
        S_SSCAN,
        S_DONE
    } seq_state_t;

    seq_state_t     state_reg;
    item_t          item_reg;
    logic [SCW-1:0] st_cnt_reg;
    logic [TCW-1:0] tr_cnt_reg;
    logic           cur_ok_reg;
    logic [SW-1:0]  cur_slot_reg;
    logic [7:0]     cur_id_reg;
    logic           def_ok_reg;
    logic [SW-1:0]  def_slot_reg;

    logic [TCW-1:0] tidx_reg;
    logic [SCW-1:0] sidx_reg;
    logic [SW-1:0]  pidx_reg;
    logic           pend_reg;

    logic           dh_ok_reg;
    logic [7:0]     dh_act_reg;
    logic [7:0]     dh_nxt_reg;
    logic           ch_ok_reg;
    logic [7:0]     ch_act_reg;
    logic [7:0]     ch_nxt_reg;
    logic           fb_ok_reg;
    logic [7:0]     fb_act_reg;
    logic [7:0]     fb_nxt_reg;

    logic [7:0]     tgt_reg;
    logic           sf_ok_reg;
    logic [SW-1:0]  sf_slot_reg;
    logic [7:0]     sf_entry_reg;

    logic [7:0]     t_act_reg;
    logic [7:0]     e_act_reg;
    status_t        status_reg;

    logic           s_full;
    logic           t_full;
    logic           s_we;
    logic           t_we;
    logic [SDW-1:0] s_wdata;
    logic [TDW-1:0] t_wdata;
    logic [SDW-1:0] s_rdata;
    logic [TDW-1:0] t_rdata;
    logic [7:0]     s_id;
    logic [7:0]     s_entry;
    logic [7:0]     t_ev;
    logic [7:0]     t_act;
    logic [7:0]     t_nxt;
    logic [SW-1:0]  t_own;

    assign s_full  = (st_cnt_reg == SCW'(MAX_STATES));
    assign t_full  = (tr_cnt_reg == TCW'(MAX_TRANSITIONS));
    assign s_we    = (state_reg == S_EXEC) && (item_reg.op == OP_ADD_STATE) && !s_full;
    assign t_we    = (state_reg == S_EXEC) && (item_reg.op == OP_ADD_TRANS)
                     && cur_ok_reg && !t_full;
    assign s_wdata = {item_reg.state_id, item_reg.action_id};
    assign t_wdata = {item_reg.event_id, item_reg.action_id, item_reg.next_state_id,
                      cur_slot_reg};

    assign s_id    = s_rdata[15:8];
    assign s_entry = s_rdata[7:0];
    assign t_ev    = t_rdata[SW+16 +: 8];
    assign t_act   = t_rdata[SW+8 +: 8];
    assign t_nxt   = t_rdata[SW +: 8];
    assign t_own   = t_rdata[SW-1:0];

    // items are handled one at a time, so a read always follows the write
    // it depends on
    tdesm_ram #(
        .WIDTH (SDW),
        .DEPTH (MAX_STATES)
    ) u_state_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (st_cnt_reg[SW-1:0]),
        .wdata (s_wdata),
        .raddr (sidx_reg[SW-1:0]),
        .rdata (s_rdata)
    );

    tdesm_ram #(
        .WIDTH (TDW),
        .DEPTH (MAX_TRANSITIONS)
    ) u_trans_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (tr_cnt_reg[TW-1:0]),
        .wdata (t_wdata),
        .raddr (tidx_reg[TW-1:0]),
        .rdata (t_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            item_reg     <= '0;
            st_cnt_reg   <= '0;
            tr_cnt_reg   <= '0;
            cur_ok_reg   <= 1'b0;
            cur_slot_reg <= '0;
            cur_id_reg   <= '0;
            def_ok_reg   <= 1'b0;
            def_slot_reg <= '0;
            tidx_reg     <= '0;
            sidx_reg     <= '0;
            pidx_reg     <= '0;
            pend_reg     <= 1'b0;
            dh_ok_reg    <= 1'b0;
            dh_act_reg   <= '0;
            dh_nxt_reg   <= '0;
            ch_ok_reg    <= 1'b0;
            ch_act_reg   <= '0;
            ch_nxt_reg   <= '0;
            fb_ok_reg    <= 1'b0;
            fb_act_reg   <= '0;
            fb_nxt_reg   <= '0;
            tgt_reg      <= '0;
            sf_ok_reg    <= 1'b0;
            sf_slot_reg  <= '0;
            sf_entry_reg <= '0;
            t_act_reg    <= '0;
            e_act_reg    <= '0;
            status_reg   <= ST_ACCEPTED;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        item_reg  <= item;
                        state_reg <= S_EXEC;
                    end
                end

                S_EXEC:
                begin
                    t_act_reg <= '0;
                    e_act_reg <= '0;
                    tidx_reg  <= '0;
                    sidx_reg  <= '0;
                    pend_reg  <= 1'b0;
                    dh_ok_reg <= 1'b0;
                    ch_ok_reg <= 1'b0;
                    fb_ok_reg <= 1'b0;
                    sf_ok_reg <= 1'b0;
                    tgt_reg   <= item_reg.state_id;
                    unique case (item_reg.op)
                        OP_ADD_STATE:
                        begin
                            if (s_full)
                            begin
                                status_reg <= ST_FULL;
                            end
                            else
                            begin
                                cur_slot_reg <= st_cnt_reg[SW-1:0];
                                cur_id_reg   <= item_reg.state_id;
                                cur_ok_reg   <= 1'b1;
                                if (item_reg.state_id == cfg.default_state_id)
                                begin
                                    def_slot_reg <= st_cnt_reg[SW-1:0];
                                    def_ok_reg   <= 1'b1;
                                end
                                st_cnt_reg <= st_cnt_reg + 1'b1;
                                status_reg <= ST_ACCEPTED;
                            end
                            state_reg <= S_DONE;
                        end
                        OP_ADD_TRANS:
                        begin
                            priority if (!cur_ok_reg)
                            begin
                                status_reg <= ST_NO_STATE;
                            end
                            else if (t_full)
                            begin
                                status_reg <= ST_FULL;
                            end
                            else
                            begin
                                tr_cnt_reg <= tr_cnt_reg + 1'b1;
                                status_reg <= ST_ACCEPTED;
                            end
                            state_reg <= S_DONE;
                        end
                        OP_FORCE:
                        begin
                            state_reg <= S_SSCAN;
                        end
                        OP_EVENT:
                        begin
                            if (!cur_ok_reg)
                            begin
                                status_reg <= ST_NO_STATE;
                                state_reg  <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_TSCAN;
                            end
                        end
                    endcase
                end

                S_TSCAN:
                begin
                    // read issued from tidx, compared in the next cycle
                    if (tidx_reg < tr_cnt_reg)
                    begin
                        tidx_reg <= tidx_reg + 1'b1;
                        pend_reg <= 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (!pend_reg)
                        begin
                            state_reg <= S_RESOLVE;
                        end
                    end
                    if (pend_reg)
                    begin
                        if (def_ok_reg && (t_own == def_slot_reg)
                            && (t_ev == item_reg.event_id))
                        begin
                            dh_ok_reg  <= 1'b1;
                            dh_act_reg <= t_act;
                            dh_nxt_reg <= t_nxt;
                        end
                        if (t_own == cur_slot_reg)
                        begin
                            priority if (t_ev == item_reg.event_id)
                            begin
                                ch_ok_reg  <= 1'b1;
                                ch_act_reg <= t_act;
                                ch_nxt_reg <= t_nxt;
                            end
                            else if (t_ev == cfg.default_event_id)
                            begin
                                fb_ok_reg  <= 1'b1;
                                fb_act_reg <= t_act;
                                fb_nxt_reg <= t_nxt;
                            end
                        end
                    end
                end

                S_RESOLVE:
                begin
                    priority if (dh_ok_reg || ch_ok_reg || fb_ok_reg)
                    begin
                        logic [7:0] nxt;
                        logic [7:0] act;
                        priority if (dh_ok_reg)
                        begin
                            nxt = dh_nxt_reg;
                            act = dh_act_reg;
                        end
                        else if (ch_ok_reg)
                        begin
                            nxt = ch_nxt_reg;
                            act = ch_act_reg;
                        end
                        else
                        begin
                            nxt = fb_nxt_reg;
                            act = fb_act_reg;
                        end
                        t_act_reg <= act;
                        tgt_reg   <= nxt;
                        if (nxt == cur_id_reg)
                        begin
                            status_reg <= ST_SAME;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_SSCAN;
                        end
                    end
                    else
                    begin
                        status_reg <= ST_NO_MATCH;
                        state_reg  <= S_DONE;
                    end
                end

                S_SSCAN:
                begin
                    if (sidx_reg < st_cnt_reg)
                    begin
                        sidx_reg <= sidx_reg + 1'b1;
                        pidx_reg <= sidx_reg[SW-1:0];
                        pend_reg <= 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg && (s_id == tgt_reg))
                    begin
                        sf_ok_reg    <= 1'b1;
                        sf_slot_reg  <= pidx_reg;
                        sf_entry_reg <= s_entry;
                    end
                    if (!pend_reg && !(sidx_reg < st_cnt_reg))
                    begin
                        if (sf_ok_reg)
                        begin
                            cur_slot_reg <= sf_slot_reg;
                            cur_id_reg   <= tgt_reg;
                            cur_ok_reg   <= 1'b1;
                            e_act_reg    <= sf_entry_reg;
                            status_reg   <= ST_CHANGED;
                        end
                        else if (item_reg.op == OP_FORCE)
                        begin
                            status_reg <= ST_FORCE_MISSING;
                        end
                        else
                        begin
                            status_reg <= ST_TARGET_MISSING;
                        end
                        state_reg <= S_DONE;
                    end
                end

                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res.transition_action = t_act_reg;
        res.entry_action      = e_act_reg;
        res.current_state     = cur_ok_reg ? cur_id_reg : 8'd0;
        res.current_valid     = cur_ok_reg;
        res.status            = status_reg;
    end

endmodule

`default_nettype wire

>>> sv/table_driven_event_state_machine_unit.sv
// ----------------------------------------------------------------------------
// table_driven_event_state_machine_unit
// Programmable table-driven state machine with APB register access.
// ----------------------------------------------------------------------------
// Items arrive on the item channel (item_valid / item_stall); each carries an
// operation: add state, add transition, force state or process event. Every
// item yields exactly one result on the result channel (result_valid /
// result_stall) with the transition action, entry action, current state and
// a status code.
// Add state and add transition are executed and go straight to the result
// register. Force state scans the state memory; process event scans the
// transition memory and, when the next state differs, the state memory:
// both scan their memory one entry per cycle through a single read port.
// One item is in work at a time.
// A finished result sits in the output register; the next item is accepted
// while it waits. If the receiver keeps stalling, the sequencer holds its
// next result and item_stall stays high until the register frees.
// Reset empties both tables (fill counts), clears the current and default
// state and sets both configuration registers to 255. No clearing pass.
// Configuration: default_state_id at 0x0, default_event_id at 0x4.
// ----------------------------------------------------------------------------
`default_nettype none

module table_driven_event_state_machine_unit #(
    parameter int MAX_STATES      = tdesm_pkg::DEF_MAX_STATES,
    parameter int MAX_TRANSITIONS = tdesm_pkg::DEF_MAX_TRANSITIONS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [7:0]  state_id,
    input  wire logic [7:0]  event_id,
    input  wire logic [7:0]  action_id,
    input  wire logic [7:0]  next_state_id,

    output logic             result_valid,
    input  wire logic        result_stall,
    output logic      [7:0]  transition_action,
    output logic      [7:0]  entry_action,
    output logic      [7:0]  current_state,
    output logic             current_valid,
    output logic      [2:0]  status
);

    import tdesm_pkg::*;

    logic       def_state_sel;
    logic [7:0] default_state_reg;
    logic [7:0] default_event_reg;
    cfg_t       cfg;
    item_t      item;
    result_t    res;
    logic       seq_idle;
    logic       seq_res_valid;
    logic       out_free;
    logic       out_valid_reg;
    result_t    out_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_state_reg <= 8'd255;
            default_event_reg <= 8'd255;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_DEFAULT_STATE)
            begin
                default_state_reg <= pwdata[7:0];
            end
            else
            begin
                default_event_reg <= pwdata[7:0];
            end
        end
    end

    assign def_state_sel = (paddr[2] == REG_DEFAULT_STATE);
    assign prdata = {24'd0, def_state_sel ? default_state_reg : default_event_reg};

    assign cfg.default_state_id = default_state_reg;
    assign cfg.default_event_id = default_event_reg;

    assign item.op            = op_t'(operation);
    assign item.state_id      = state_id;
    assign item.event_id      = event_id;
    assign item.action_id     = action_id;
    assign item.next_state_id = next_state_id;

    assign out_free   = !out_valid_reg || !result_stall;
    assign item_stall = !seq_idle;

    tdesm_seq #(
        .MAX_STATES      (MAX_STATES),
        .MAX_TRANSITIONS (MAX_TRANSITIONS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .start     (item_valid),
        .item      (item),
        .idle      (seq_idle),
        .res_valid (seq_res_valid),
        .res_ready (out_free),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (out_free)
        begin
            out_valid_reg <= seq_res_valid;
            if (seq_res_valid)
            begin
                out_reg <= res;
            end
        end
    end

    assign result_valid      = out_valid_reg;
    assign transition_action = out_reg.transition_action;
    assign entry_action      = out_reg.entry_action;
    assign current_state     = out_reg.current_state;
    assign current_valid     = out_reg.current_valid;
    assign status            = out_reg.status;

`include "table_driven_event_state_machine_unit_assert.svh"

    `TDESM_ASSERT_NXT(a_busy_after_accept, clk, rst_n, item_valid && !item_stall, item_stall)
    `TDESM_ASSERT_IMP(a_no_state_invalid, clk, rst_n,
                      result_valid && (status == ST_NO_STATE), !current_valid)
    `TDESM_ASSERT_IMP(a_entry_only_on_change, clk, rst_n,
                      result_valid && (status != ST_CHANGED), entry_action == 8'd0)
    `TDESM_ASSERT_IMP(a_state_zero_when_none, clk, rst_n,
                      result_valid && !current_valid, current_state == 8'd0)

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the table-driven event state machine unit.
// Items are pushed through the valid/stall channel from a backlog queue; a
// behavioral copy of the machine predicts each result, which is compared
// field by field with what comes out. Register writes go over APB between
// phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import tdesm_pkg::*;

    localparam int NUM_STATES     = DEF_MAX_STATES;
    localparam int NUM_TRANS      = DEF_MAX_TRANSITIONS;
    localparam int ITEMS_PER_PASS = 650;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 100;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid;
    logic        item_stall;
    logic [1:0]  operation;
    logic [7:0]  state_id;
    logic [7:0]  event_id;
    logic [7:0]  action_id;
    logic [7:0]  next_state_id;
    logic        result_valid;
    logic        result_stall;
    logic [7:0]  transition_action;
    logic [7:0]  entry_action;
    logic [7:0]  current_state;
    logic        current_valid;
    logic [2:0]  status;

    // machine copy
    logic [7:0]  cfg_def_state;
    logic [7:0]  cfg_def_event;
    logic [7:0]  st_id    [NUM_STATES];
    logic [7:0]  st_entry [NUM_STATES];
    logic [7:0]  tr_event [NUM_TRANS];
    logic [7:0]  tr_action[NUM_TRANS];
    logic [7:0]  tr_next  [NUM_TRANS];
    int          tr_owner [NUM_TRANS];
    int          n_states;
    int          n_trans;
    int          cur_slot;
    logic        cur_ok;
    int          def_slot;
    logic        def_ok;

    item_t       item_backlog[$];
    result_t     pending_results[$];
    item_t       next_item;
    logic        item_taken;
    int          sender_idle_pct;
    int          receiver_idle_pct;
    int          errors;
    int          quiet_cycles;

    table_driven_event_state_machine_unit DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .operation        (operation),
        .state_id         (state_id),
        .event_id         (event_id),
        .action_id        (action_id),
        .next_state_id    (next_state_id),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .transition_action(transition_action),
        .entry_action     (entry_action),
        .current_state    (current_state),
        .current_valid    (current_valid),
        .status           (status)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int lookup_state(input logic [7:0] id);
        int found;
        found = -1;
        for (int i = 0; i < n_states; i++)
            if (st_id[i] == id)
                found = i;
        return found;
    endfunction

    task automatic advance_machine(input item_t it, output result_t r);
        int s;
        int hit;
        int fallback;
        r = '0;
        r.status = ST_ACCEPTED;
        case (it.op)
            OP_ADD_STATE:
            begin
                if (n_states >= NUM_STATES)
                    r.status = ST_FULL;
                else
                begin
                    st_id[n_states] = it.state_id;
                    st_entry[n_states] = it.action_id;
                    cur_slot = n_states;
                    cur_ok = 1'b1;
                    if (it.state_id == cfg_def_state)
                    begin
                        def_slot = n_states;
                        def_ok = 1'b1;
                    end
                    n_states++;
                end
            end
            OP_ADD_TRANS:
            begin
                if (!cur_ok)
                    r.status = ST_NO_STATE;
                else if (n_trans >= NUM_TRANS)
                    r.status = ST_FULL;
                else
                begin
                    tr_event[n_trans] = it.event_id;
                    tr_action[n_trans] = it.action_id;
                    tr_next[n_trans] = it.next_state_id;
                    tr_owner[n_trans] = cur_slot;
                    n_trans++;
                end
            end
            OP_FORCE:
            begin
                s = lookup_state(it.state_id);
                if (s < 0)
                    r.status = ST_FORCE_MISSING;
                else
                begin
                    cur_slot = s;
                    cur_ok = 1'b1;
                    r.entry_action = st_entry[s];
                    r.status = ST_CHANGED;
                end
            end
            default:
            begin
                if (!cur_ok)
                    r.status = ST_NO_STATE;
                else
                begin
                    hit = -1;
                    fallback = -1;
                    if (def_ok)
                        for (int i = 0; i < n_trans; i++)
                            if (tr_owner[i] == def_slot && tr_event[i] == it.event_id)
                                hit = i;
                    if (hit < 0)
                        for (int i = 0; i < n_trans; i++)
                            if (tr_owner[i] == cur_slot)
                            begin
                                if (tr_event[i] == it.event_id)
                                    hit = i;
                                else if (tr_event[i] == cfg_def_event)
                                    fallback = i;
                            end
                    if (hit < 0)
                        hit = fallback;
                    if (hit < 0)
                        r.status = ST_NO_MATCH;
                    else
                    begin
                        r.transition_action = tr_action[hit];
                        if (tr_next[hit] == st_id[cur_slot])
                            r.status = ST_SAME;
                        else
                        begin
                            s = lookup_state(tr_next[hit]);
                            if (s < 0)
                                r.status = ST_TARGET_MISSING;
                            else
                            begin
                                cur_slot = s;
                                r.entry_action = st_entry[s];
                                r.status = ST_CHANGED;
                            end
                        end
                    end
                end
            end
        endcase
        r.current_state = cur_ok ? st_id[cur_slot] : 8'd0;
        r.current_valid = cur_ok;
    endtask

    function automatic item_t make_item(input op_t op, input logic [7:0] sid,
                                        input logic [7:0] ev, input logic [7:0] act,
                                        input logic [7:0] nxt);
        item_t it;
        it.op = op;
        it.state_id = sid;
        it.event_id = ev;
        it.action_id = act;
        it.next_state_id = nxt;
        return it;
    endfunction

    // mostly a small pool of ids so that lookups hit
    function automatic logic [7:0] pick_state_id();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return 8'($urandom_range(7));
        else if (r < 90)
            return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_event_id();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 8'($urandom_range(5));
        else if (r < 85)
            return cfg_def_event;
        return 8'($urandom_range(255));
    endfunction

    function automatic item_t random_item();
        int r;
        item_t it;
        r = $urandom_range(99);
        if (r < 5)
            return item_t'({2'($urandom_range(3)), 32'($urandom)});
        it.op = r < 18 ? OP_ADD_STATE : r < 42 ? OP_ADD_TRANS : r < 56 ? OP_FORCE : OP_EVENT;
        it.state_id = pick_state_id();
        it.event_id = pick_event_id();
        it.action_id = 8'($urandom_range(255));
        it.next_state_id = pick_state_id();
        return it;
    endfunction

    task automatic write_reg(input logic idx, input logic [7:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_DEFAULT_STATE)
            cfg_def_state = value;
        else
            cfg_def_event = value;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (item_backlog.size() != 0 || item_valid || pending_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] expv,
                               input logic [7:0] got);
        if (expv !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, expv, got);
            errors++;
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item_valid || item_taken)
            begin
                if (item_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    next_item = item_backlog.pop_front();
                    operation <= next_item.op;
                    state_id <= next_item.state_id;
                    event_id <= next_item.event_id;
                    action_id <= next_item.action_id;
                    next_state_id <= next_item.next_state_id;
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
            result_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        result_t exp_r;
        item_taken = 1'b0;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                item_taken = 1'b1;
                advance_machine(make_item(op_t'(operation), state_id, event_id,
                                          action_id, next_state_id), exp_r);
                pending_results.push_back(exp_r);
            end
            if (result_valid && !result_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected item, status %0d state %0h", $time, status,
                             current_state);
                    errors++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    check_field("transition_action", exp_r.transition_action,
                                transition_action);
                    check_field("entry_action", exp_r.entry_action, entry_action);
                    check_field("current_state", exp_r.current_state, current_state);
                    check_field("current_valid", 8'(exp_r.current_valid), 8'(current_valid));
                    check_field("status", 8'(exp_r.status), 8'(status));
                end
            end
            if (item_taken || (result_valid && !result_stall) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_valid = 1'b0;
        operation = '0;
        state_id = '0;
        event_id = '0;
        action_id = '0;
        next_state_id = '0;
        result_stall = 1'b0;
        item_taken = 1'b0;
        errors = 0;
        quiet_cycles = 0;
        sender_idle_pct = 33;
        receiver_idle_pct = 83;
        cfg_def_state = 8'd255;
        cfg_def_event = 8'd255;
        n_states = 0;
        n_trans = 0;
        cur_slot = 0;
        cur_ok = 1'b0;
        def_slot = 0;
        def_ok = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(REG_DEFAULT_STATE, 8'd2);
        write_reg(REG_DEFAULT_EVENT, 8'd0);

        item_backlog.push_back(make_item(OP_EVENT, 8'd0, 8'd5, 8'd0, 8'd0));
        item_backlog.push_back(make_item(OP_ADD_TRANS, 8'd0, 8'd1, 8'd9, 8'd0));
        item_backlog.push_back(make_item(OP_FORCE, 8'd9, 8'd0, 8'd0, 8'd0));
        item_backlog.push_back(make_item(OP_ADD_STATE, 8'd0, 8'd0, 8'h00, 8'd0));
        item_backlog.push_back(make_item(OP_ADD_STATE, 8'd255, 8'd255, 8'hff, 8'd255));
        // id 2 becomes the default state
        item_backlog.push_back(make_item(OP_ADD_STATE, 8'd2, 8'd0, 8'h81, 8'd0));
        item_backlog.push_back(make_item(OP_ADD_TRANS, 8'd0, 8'd1, 8'h11, 8'd0));
        item_backlog.push_back(make_item(OP_FORCE, 8'd255, 8'd0, 8'd0, 8'd0));
        item_backlog.push_back(make_item(OP_ADD_TRANS, 8'd0, 8'd1, 8'h22, 8'd2));
        item_backlog.push_back(make_item(OP_ADD_TRANS, 8'd0, 8'd3, 8'h33, 8'd255));
        item_backlog.push_back(make_item(OP_ADD_TRANS, 8'd0, 8'd0, 8'h44, 8'd0));
        item_backlog.push_back(make_item(OP_ADD_TRANS, 8'd0, 8'd4, 8'hff, 8'd77));
        item_backlog.push_back(make_item(OP_EVENT, 8'd0, 8'd1, 8'd0, 8'd0));
        item_backlog.push_back(make_item(OP_FORCE, 8'd255, 8'd0, 8'd0, 8'd0));
        item_backlog.push_back(make_item(OP_EVENT, 8'd0, 8'd3, 8'd0, 8'd0));
        item_backlog.push_back(make_item(OP_EVENT, 8'd0, 8'd4, 8'd0, 8'd0));
        item_backlog.push_back(make_item(OP_EVENT, 8'd0, 8'd200, 8'd0, 8'd0));
        item_backlog.push_back(make_item(OP_EVENT, 8'd0, 8'd9, 8'd0, 8'd0));
        // duplicate id, later lookups take this one
        item_backlog.push_back(make_item(OP_ADD_STATE, 8'd0, 8'd0, 8'h55, 8'd0));
        item_backlog.push_back(make_item(OP_FORCE, 8'd0, 8'd0, 8'd0, 8'd0));
        item_backlog.push_back(make_item(OP_ADD_TRANS, 8'd0, 8'd255, 8'h66, 8'd255));
        item_backlog.push_back(make_item(OP_EVENT, 8'd0, 8'd255, 8'd0, 8'd0));
        item_backlog.push_back(make_item(OP_EVENT, 8'd0, 8'd1, 8'd0, 8'd0));
        wait_drained();

        for (int pass = 0; pass < 3; pass++)
        begin
            case (pass)
                0:
                begin
                    write_reg(REG_DEFAULT_STATE, 8'd3);
                    write_reg(REG_DEFAULT_EVENT, 8'd5);
                end
                1:
                begin
                    sender_idle_pct = 83;
                    receiver_idle_pct = 33;
                    write_reg(REG_DEFAULT_STATE, 8'd255);
                    write_reg(REG_DEFAULT_EVENT, 8'd255);
                end
                default:
                begin
                    sender_idle_pct = 0;
                    receiver_idle_pct = 0;
                    write_reg(REG_DEFAULT_STATE, 8'd0);
                    write_reg(REG_DEFAULT_EVENT, 8'd0);
                end
            endcase
            for (int i = 0; i < ITEMS_PER_PASS; i++)
                item_backlog.push_back(random_item());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
